// ===== design/rbb_pkg.sv =====
// Shared types, constants and sine helpers for the rotated bounding box block.
// Used by every module of the block; it depends on nothing else.
package rbb_pkg;

  localparam int CoordWidthDef = 20;
  localparam int PackW = 20;
  localparam int ScaleW = 16;
  localparam int AngW = 16;
  localparam int TrigW = 16;
  localparam int QueueDepth = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 60;

  localparam logic [1:0] ModeReset = 2'd0;
  localparam logic [59:0] SizeReset = 60'd0;
  localparam logic [47:0] ScaleReset = 48'h1000_1000_1000;
  localparam logic [59:0] PosReset = 60'd0;
  localparam logic [31:0] AngReset = 32'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOX_MODE  = 3'd0,
    REG_SIZE      = 3'd1,
    REG_SCALE     = 3'd2,
    REG_POSITION  = 3'd3,
    REG_ANGLES    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Quarter-wave sine, round(16384*sin(k*pi/128)) for k = 0..64.
  function automatic logic signed [TrigW-1:0] sin_tab(input logic [6:0] idx);
    logic signed [TrigW-1:0] v;
    case (idx)
      7'd0: v = 16'sd0;        7'd1: v = 16'sd402;      7'd2: v = 16'sd804;
      7'd3: v = 16'sd1205;     7'd4: v = 16'sd1606;     7'd5: v = 16'sd2006;
      7'd6: v = 16'sd2404;     7'd7: v = 16'sd2801;     7'd8: v = 16'sd3196;
      7'd9: v = 16'sd3590;     7'd10: v = 16'sd3981;    7'd11: v = 16'sd4370;
      7'd12: v = 16'sd4756;    7'd13: v = 16'sd5139;    7'd14: v = 16'sd5520;
      7'd15: v = 16'sd5897;    7'd16: v = 16'sd6270;    7'd17: v = 16'sd6639;
      7'd18: v = 16'sd7005;    7'd19: v = 16'sd7366;    7'd20: v = 16'sd7723;
      7'd21: v = 16'sd8076;    7'd22: v = 16'sd8423;    7'd23: v = 16'sd8765;
      7'd24: v = 16'sd9102;    7'd25: v = 16'sd9434;    7'd26: v = 16'sd9760;
      7'd27: v = 16'sd10080;   7'd28: v = 16'sd10394;   7'd29: v = 16'sd10702;
      7'd30: v = 16'sd11003;   7'd31: v = 16'sd11297;   7'd32: v = 16'sd11585;
      7'd33: v = 16'sd11866;   7'd34: v = 16'sd12140;   7'd35: v = 16'sd12406;
      7'd36: v = 16'sd12665;   7'd37: v = 16'sd12916;   7'd38: v = 16'sd13160;
      7'd39: v = 16'sd13395;   7'd40: v = 16'sd13623;   7'd41: v = 16'sd13842;
      7'd42: v = 16'sd14053;   7'd43: v = 16'sd14256;   7'd44: v = 16'sd14449;
      7'd45: v = 16'sd14635;   7'd46: v = 16'sd14811;   7'd47: v = 16'sd14978;
      7'd48: v = 16'sd15137;   7'd49: v = 16'sd15286;   7'd50: v = 16'sd15426;
      7'd51: v = 16'sd15557;   7'd52: v = 16'sd15679;   7'd53: v = 16'sd15791;
      7'd54: v = 16'sd15893;   7'd55: v = 16'sd15986;   7'd56: v = 16'sd16069;
      7'd57: v = 16'sd16143;   7'd58: v = 16'sd16207;   7'd59: v = 16'sd16261;
      7'd60: v = 16'sd16305;   7'd61: v = 16'sd16340;   7'd62: v = 16'sd16364;
      7'd63: v = 16'sd16379;
      default: v = 16'sd16384;
    endcase
    return v;
  endfunction

  // First-quadrant sine of x in 0..16384, interpolated on the low 8 bits.
  function automatic logic signed [TrigW-1:0] sin_q(input logic [14:0] x);
    logic [6:0] i;
    logic signed [TrigW-1:0] a;
    logic signed [TrigW-1:0] b;
    logic signed [TrigW-1:0] d;
    logic signed [TrigW+9:0] m;
    i = x[14:8];
    a = sin_tab(i);
    b = sin_tab(i + 7'd1);
    d = b - a;
    m = d * $signed({1'b0, x[7:0]}) + 26'sd128;
    if (i >= 7'd64) begin
      return 16'sd16384;
    end
    return a + m[TrigW+7:8];
  endfunction

  function automatic logic signed [TrigW-1:0] sine(input logic [AngW-1:0] ang);
    logic [14:0] p;
    logic [14:0] r;
    p = {1'b0, ang[13:0]};
    r = 15'd16384 - p;
    case (ang[15:14])
      2'd0: return sin_q(p);
      2'd1: return sin_q(r);
      2'd2: return -sin_q(p);
      default: return -sin_q(r);
    endcase
  endfunction

endpackage

// ===== design/rbb_queue.sv =====
// Short job queue between the front and the back of the bounding box block.
// Depends on rbb_pkg for the status struct.
module rbb_queue import rbb_pkg::*; #(
  parameter int DataW = 121,
  parameter int Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o,
  output q_status_t        stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  assign data_o = mem_q[rd_q];
  assign stat_o.full = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

// ===== design/rbb_front.sv =====
// Front end: accepts mesh box beats, keeps the running min/max and posts jobs.
// Depends on rbb_pkg for the queue status struct.
module rbb_front import rbb_pkg::*; #(
  parameter int CoordWidth = CoordWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     geom_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [6*CoordWidth-1:0]  in_data_i,
  input  logic                     in_last_i,
  input  q_status_t                q_stat_i,
  output logic                     push_o,
  output logic [6*CoordWidth:0]    job_o
);

  localparam int W = CoordWidth;
  localparam logic signed [W-1:0] MaxV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MinV = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] run_min_q [3];
  logic signed [W-1:0] run_max_q [3];
  logic signed [W-1:0] run_min_d [3];
  logic signed [W-1:0] run_max_d [3];
  logic accept;

  assign in_ready_o = !q_stat_i.full;
  assign accept = in_valid_i && in_ready_o;
  assign push_o = accept && (!geom_i || in_last_i);

  always_comb begin
    logic signed [W-1:0] p, q, mn, mx;
    job_o = '0;
    job_o[0] = geom_i;
    for (int k = 0; k < 3; k++) begin
      p = in_data_i[k*W +: W];
      q = in_data_i[(k+3)*W +: W];
      mn = run_min_q[k];
      mx = run_max_q[k];
      if (p < mn) mn = p;
      if (q < mn) mn = q;
      if (p > mx) mx = p;
      if (q > mx) mx = q;
      run_min_d[k] = mn;
      run_max_d[k] = mx;
      job_o[1 + k*W +: W] = mn;
      job_o[1 + (k+3)*W +: W] = mx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        run_min_q[k] <= MaxV;
        run_max_q[k] <= MinV;
      end
    end else if (accept && geom_i) begin
      for (int k = 0; k < 3; k++) begin
        run_min_q[k] <= in_last_i ? MaxV : run_min_d[k];
        run_max_q[k] <= in_last_i ? MinV : run_max_d[k];
      end
    end
  end

endmodule

// ===== design/rbb_back.sv =====
// Back end: a sequencer on one shared multiplier that scales each job, rotates
// it if geometric, bounds it and adds position with saturation. Uses rbb_pkg.
module rbb_back import rbb_pkg::*; #(
  parameter int CoordWidth = CoordWidthDef,
  parameter int OutDataW = 120
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [6*CoordWidth:0]    job_i,
  input  q_status_t                q_stat_i,
  output logic                     pop_o,
  input  logic                     bottom_i,
  input  logic [59:0]              size_i,
  input  logic [47:0]              scale_i,
  input  logic [59:0]              pos_i,
  input  logic [31:0]              ang_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [OutDataW-1:0]      out_data_o,
  output logic                     out_user_o
);

  localparam int W = CoordWidth;
  localparam int RW = (W + 7 > 26) ? W + 7 : 26;
  localparam int BW = 18;
  localparam int PW = RW + BW;
  localparam int SW = RW + 1;
  localparam logic signed [PW:0] Half14 = {{(PW-13){1'b0}}, 1'b1, 13'd0};
  localparam logic signed [PW:0] Half12 = {{(PW-11){1'b0}}, 1'b1, 11'd0};
  localparam logic signed [PW:0] Half13 = {{(PW-12){1'b0}}, 1'b1, 12'd0};
  localparam logic signed [SW-1:0] SatHi = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SatLo = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE, ST_TRIG, ST_SCALE, ST_ROT, ST_SIZE, ST_OUT
  } state_e;

  state_e state_q;
  logic [3:0] step_q;
  logic phase_q;
  logic [2:0] corner_q;
  logic signed [TrigW-1:0] sp_q, cp_q, sy_q, cy_q;
  logic signed [W-1:0] mn_q [3];
  logic signed [W-1:0] mx_q [3];
  logic signed [RW-1:0] av_q [3];
  logic signed [RW-1:0] bv_q [3];
  logic signed [RW-1:0] lo_q [3];
  logic signed [RW-1:0] hi_q [3];
  logic signed [RW-1:0] y1_q, z1_q, x2_q, z2_q;
  logic signed [PW-1:0] prod_q, acc_q;
  logic out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic out_user_q;

  logic [1:0] kidx;
  logic signed [RW-1:0] opa, cx, cyv, cz;
  logic signed [BW-1:0] opb, scl;
  logic signed [PW-1:0] prod_d;
  logic signed [PW:0] rsum, r14, r12, r13;
  logic signed [TrigW-1:0] trig_d;
  logic [AngW-1:0] trig_ang;
  logic [OutDataW-1:0] fin_data;
  logic fin_clip;

  assign kidx = (step_q < 4'd3) ? step_q[1:0] : 2'(step_q - 4'd3);
  assign scl = $signed({2'b00, scale_i[kidx*ScaleW +: ScaleW]});
  assign cx = corner_q[2] ? bv_q[0] : av_q[0];
  assign cyv = corner_q[1] ? bv_q[1] : av_q[1];
  assign cz = corner_q[0] ? bv_q[2] : av_q[2];

  always_comb begin
    opa = '0;
    opb = '0;
    case (state_q)
      ST_SCALE: begin
        opa = (step_q < 4'd3) ? RW'(mn_q[kidx]) : RW'(mx_q[kidx]);
        opb = scl;
      end
      ST_SIZE: begin
        opa = $signed(RW'(size_i[kidx*PackW +: PackW]));
        opb = scl;
      end
      ST_ROT: begin
        case (step_q)
          4'd0: begin opa = cyv; opb = BW'(cp_q); end
          4'd1: begin opa = cz;  opb = BW'(sp_q); end
          4'd2: begin opa = cyv; opb = BW'(sp_q); end
          4'd3: begin opa = cz;  opb = BW'(cp_q); end
          4'd4: begin opa = cx;  opb = BW'(cy_q); end
          4'd5: begin opa = z1_q; opb = BW'(sy_q); end
          4'd6: begin opa = z1_q; opb = BW'(cy_q); end
          4'd7: begin opa = cx;  opb = BW'(sy_q); end
          default: begin opa = '0; opb = '0; end
        endcase
      end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign prod_d = opa * opb;
  // Second product of a pair is subtracted for y1 and z2.
  assign rsum = (step_q == 4'd1 || step_q == 4'd7) ?
                (PW+1)'(acc_q) - (PW+1)'(prod_q) : (PW+1)'(acc_q) + (PW+1)'(prod_q);
  assign r14 = rsum + Half14;
  assign r12 = (PW+1)'(prod_q) + Half12;
  assign r13 = (PW+1)'(prod_q) + Half13;

  always_comb begin
    case (step_q[1:0])
      2'd0: trig_ang = ang_i[31:16];
      2'd1: trig_ang = ang_i[31:16] + 16'd16384;
      2'd2: trig_ang = ang_i[15:0];
      default: trig_ang = ang_i[15:0] + 16'd16384;
    endcase
    trig_d = sine(trig_ang);
  end

  always_comb begin
    logic signed [SW-1:0] s;
    logic signed [W-1:0] v;
    fin_data = '0;
    fin_clip = 1'b0;
    for (int k = 0; k < 6; k++) begin
      s = ((k < 3) ? SW'(lo_q[k % 3]) : SW'(hi_q[k % 3]))
          + SW'($signed(pos_i[(k % 3)*PackW +: PackW]));
      if (s > SatHi) begin
        v = SatHi[W-1:0];
        fin_clip = 1'b1;
      end else if (s < SatLo) begin
        v = SatLo[W-1:0];
        fin_clip = 1'b1;
      end else begin
        v = s[W-1:0];
      end
      fin_data[k*W +: W] = v;
    end
  end

  assign pop_o = (state_q == ST_IDLE) && !q_stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
      phase_q <= 1'b0;
      corner_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // In ST_OUT the output register is reloaded below instead.
      if (out_valid_q && out_ready_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      if (!phase_q) begin
        prod_q <= prod_d;
      end
      case (state_q)
        ST_IDLE: begin
          if (!q_stat_i.empty) begin
            for (int k = 0; k < 3; k++) begin
              mn_q[k] <= job_i[1 + k*W +: W];
              mx_q[k] <= job_i[1 + (k+3)*W +: W];
            end
            step_q <= '0;
            phase_q <= 1'b0;
            corner_q <= '0;
            state_q <= job_i[0] ? ST_TRIG : ST_SIZE;
          end
        end
        ST_TRIG: begin
          case (step_q[1:0])
            2'd0: sp_q <= trig_d;
            2'd1: cp_q <= trig_d;
            2'd2: sy_q <= trig_d;
            default: cy_q <= trig_d;
          endcase
          step_q <= (step_q == 4'd3) ? 4'd0 : step_q + 4'd1;
          if (step_q == 4'd3) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            if (step_q < 4'd3) av_q[kidx] <= r12[12 +: RW];
            else bv_q[kidx] <= r12[12 +: RW];
            step_q <= (step_q == 4'd5) ? 4'd0 : step_q + 4'd1;
            if (step_q == 4'd5) begin
              state_q <= ST_ROT;
            end
          end
        end
        ST_ROT: begin
          if (step_q == 4'd8) begin
            // Fold this corner into the running box; corner 0 seeds it.
            if (corner_q == 3'd0 || x2_q < lo_q[0]) lo_q[0] <= x2_q;
            if (corner_q == 3'd0 || x2_q > hi_q[0]) hi_q[0] <= x2_q;
            if (corner_q == 3'd0 || y1_q < lo_q[1]) lo_q[1] <= y1_q;
            if (corner_q == 3'd0 || y1_q > hi_q[1]) hi_q[1] <= y1_q;
            if (corner_q == 3'd0 || z2_q < lo_q[2]) lo_q[2] <= z2_q;
            if (corner_q == 3'd0 || z2_q > hi_q[2]) hi_q[2] <= z2_q;
            step_q <= '0;
            phase_q <= 1'b0;
            corner_q <= corner_q + 3'd1;
            if (corner_q == 3'd7) begin
              state_q <= ST_OUT;
            end
          end else begin
            phase_q <= !phase_q;
            if (phase_q) begin
              if (!step_q[0]) begin
                acc_q <= prod_q;
              end else begin
                case (step_q)
                  4'd1: y1_q <= r14[14 +: RW];
                  4'd3: z1_q <= r14[14 +: RW];
                  4'd5: x2_q <= r14[14 +: RW];
                  default: z2_q <= r14[14 +: RW];
                endcase
              end
              step_q <= step_q + 4'd1;
            end
          end
        end
        ST_SIZE: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            if (kidx == 2'd1 && bottom_i) begin
              lo_q[kidx] <= '0;
              hi_q[kidx] <= r12[12 +: RW];
            end else begin
              lo_q[kidx] <= -r13[13 +: RW];
              hi_q[kidx] <= r13[13 +: RW];
            end
            step_q <= (step_q == 4'd2) ? 4'd0 : step_q + 4'd1;
            if (step_q == 4'd2) begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_data_q <= fin_data;
            out_user_q <= fin_clip;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;
  assign out_user_o = out_user_q;

endmodule

// ===== design/rotated_bounding_box.sv =====
// Top level of the rotated bounding box block: configuration registers, the
// front end, the job queue and the back end. Depends on rbb_pkg and submodules.
//
// Use: mesh boxes of one object arrive as beats on the s_axis channel, the
// last one flagged by s_axis_tlast. In geometry mode (box_mode bit 0) the
// front keeps a per-axis running min/max and accepts one beat per cycle while
// the job queue is not full; the final beat posts a job. In size mode every
// beat posts a job and the corner fields are ignored. Each job yields one
// world box beat on m_axis, with tuser set when a coordinate saturated.
// The back end runs every job through one shared multiplier: a geometry job
// takes 4 sine lookups, 6 scale products, then the rotation of each of the 8
// corners, and a size job one scale product per axis. The job queue holds
// two jobs, so the front keeps accepting while the back works; it stalls only
// when both slots are full.
// Configuration beats (cfg_valid_i, cfg_index_i, cfg_data_i) are always taken
// and must arrive only while the block is idle. Reset restores the register
// defaults (scale 1.0), clears the running box and empties queue and output.
// A stalled receiver holds the output register; one finished result may wait
// there while the next job is computed.
module rotated_bounding_box import rbb_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: lo_corner_x, lo_corner_y, lo_corner_z, hi_corner_x, hi_corner_y,
  // hi_corner_z, from the lowest bit up, zero padded to whole bytes.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  input  logic                                 s_axis_tlast,
  // tdata: box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((6*COORD_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  // tuser: clipped.
  output logic                                 m_axis_tuser,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]                   cfg_index_i,
  input  logic [CfgDataW-1:0]                  cfg_data_i
);

  localparam int W = COORD_WIDTH;
  localparam int DataW = ((6*W+7)/8)*8;
  localparam int JobW = 6*W + 1;

  logic [1:0] mode_q;
  logic [59:0] size_q;
  logic [47:0] scale_q;
  logic [59:0] pos_q;
  logic [31:0] ang_q;

  logic push;
  logic pop;
  logic [JobW-1:0] job_in, job_out;
  q_status_t q_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
      size_q <= SizeReset;
      scale_q <= ScaleReset;
      pos_q <= PosReset;
      ang_q <= AngReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BOX_MODE: mode_q <= cfg_data_i[1:0];
        REG_SIZE: size_q <= cfg_data_i[59:0];
        REG_SCALE: scale_q <= cfg_data_i[47:0];
        REG_POSITION: pos_q <= cfg_data_i[59:0];
        REG_ANGLES: ang_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  rbb_front #(.CoordWidth(W)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .geom_i     (mode_q[0]),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata[6*W-1:0]),
    .in_last_i  (s_axis_tlast),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (job_in)
  );

  rbb_queue #(.DataW(JobW), .Depth(QueueDepth)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .pop_i  (pop),
    .data_o (job_out),
    .stat_o (q_stat)
  );

  rbb_back #(.CoordWidth(W), .OutDataW(DataW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .bottom_i    (mode_q[1]),
    .size_i      (size_q),
    .scale_i     (scale_q),
    .pos_i       (pos_q),
    .ang_i       (ang_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

// ===== design/rbb_checker.sv =====
// Port-level checks for the rotated bounding box block, bound to the top.
// Depends on rbb_pkg for configuration port widths.
module rbb_checker import rbb_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input logic s_axis_tlast,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((6*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input logic m_axis_tuser,
  input logic cfg_valid_i,
  input logic cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [CfgDataW-1:0] cfg_data_i
);

  localparam int W = COORD_WIDTH;
  localparam logic [W-1:0] TopV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] BotV = {1'b1, {(W-1){1'b0}}};

  logic at_rail;

  always_comb begin
    at_rail = 1'b0;
    for (int k = 0; k < 6; k++) begin
      if (m_axis_tdata[k*W +: W] == TopV || m_axis_tdata[k*W +: W] == BotV) begin
        at_rail = 1'b1;
      end
    end
  end

  // The output register is cleared by reset.
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result beat offered during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // A clipped result must show at least one coordinate on a rail.
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> at_rail)
    else $error("clipped flag without a saturated coordinate");

  // Saturation is monotonic, so every emitted box keeps lo <= hi per axis.
  for (genvar k = 0; k < 3; k++) begin : g_order
    a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |->
        $signed(m_axis_tdata[k*W +: W]) <= $signed(m_axis_tdata[(k+3)*W +: W]))
      else $error("result box has lo above hi");
  end

endmodule

bind rotated_bounding_box rbb_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbb_checker (.*);

// ===== dv/rbb_checker.sv =====
// Scoreboard for the rotated bounding box block: watches the input, output and
// configuration channels, predicts each world box and compares. Uses rbb_pkg.
module rbb_scoreboard import rbb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [119:0]        s_axis_tdata,
  input  logic                s_axis_tlast,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [119:0]        m_axis_tdata,
  input  logic                m_axis_tuser,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count,
  output int                  pending,
  output int                  results_seen
);

  localparam longint CoordMax = 524287;
  localparam longint CoordMin = -524288;

  typedef struct packed {
    logic [119:0] coords;
    logic         clip;
  } world_box_t;

  int quarter_sine [65] = '{
    0, 402, 804, 1205, 1606, 2006, 2404, 2801, 3196, 3590, 3981, 4370, 4756,
    5139, 5520, 5897, 6270, 6639, 7005, 7366, 7723, 8076, 8423, 8765, 9102,
    9434, 9760, 10080, 10394, 10702, 11003, 11297, 11585, 11866, 12140,
    12406, 12665, 12916, 13160, 13395, 13623, 13842, 14053, 14256, 14449,
    14635, 14811, 14978, 15137, 15286, 15426, 15557, 15679, 15791, 15893,
    15986, 16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379, 16384};

  logic [1:0]  mode_q;
  logic [59:0] size_q;
  logic [47:0] scale_q;
  logic [59:0] pos_q;
  logic [31:0] ang_q;
  longint      union_min [3];
  longint      union_max [3];
  world_box_t  expected_boxes [$];

  function automatic longint sext20(input logic [19:0] v);
    return longint'($signed(v));
  endfunction

  // Round half up, then drop n fraction bits.
  function automatic longint round_down(input longint v, input int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint first_quadrant(input int x);
    int i;
    int f;
    i = x >> 8;
    f = x & 255;
    if (i >= 64) return 16384;
    return quarter_sine[i] + (((quarter_sine[i+1] - quarter_sine[i]) * f + 128) >> 8);
  endfunction

  function automatic longint sine_of(input logic [15:0] a);
    int p;
    p = int'(a[13:0]);
    case (a[15:14])
      2'd0: return first_quadrant(p);
      2'd1: return first_quadrant(16384 - p);
      2'd2: return -first_quadrant(p);
      default: return -first_quadrant(16384 - p);
    endcase
  endfunction

  function automatic longint clamp(input longint v, inout logic clip);
    if (v > CoordMax) begin
      clip = 1'b1;
      return CoordMax;
    end
    if (v < CoordMin) begin
      clip = 1'b1;
      return CoordMin;
    end
    return v;
  endfunction

  task automatic clear_union();
    for (int k = 0; k < 3; k++) begin
      union_min[k] = CoordMax;
      union_max[k] = CoordMin;
    end
  endtask

  // Updates the running union for one mesh box in geometry mode and queues the
  // world box that the beat produces, if any.
  task automatic predict_world_box(input logic [119:0] d, input logic last);
    longint lo [3];
    longint hi [3];
    longint a [3];
    longint b [3];
    longint v [3];
    longint sp, cp, sy, cy, x, y, z, y1, z1, x2, z2, s, h, sc;
    logic [15:0] pitch, yaw;
    world_box_t wb;
    logic clip;
    clip = 1'b0;
    if (mode_q[0]) begin
      for (int k = 0; k < 3; k++) begin
        x = sext20(d[k*20 +: 20]);
        y = sext20(d[(k+3)*20 +: 20]);
        if (x < union_min[k]) union_min[k] = x;
        if (y < union_min[k]) union_min[k] = y;
        if (x > union_max[k]) union_max[k] = x;
        if (y > union_max[k]) union_max[k] = y;
      end
      if (!last) return;
      yaw = ang_q[15:0];
      pitch = ang_q[31:16];
      sp = sine_of(pitch);
      cp = sine_of(pitch + 16'd16384);
      sy = sine_of(yaw);
      cy = sine_of(yaw + 16'd16384);
      for (int k = 0; k < 3; k++) begin
        sc = longint'(scale_q[k*16 +: 16]);
        a[k] = round_down(union_min[k] * sc, 12);
        b[k] = round_down(union_max[k] * sc, 12);
      end
      // Rotate all eight corners, pitch about X first, then yaw about Y.
      for (int c = 0; c < 8; c++) begin
        x = c[2] ? b[0] : a[0];
        y = c[1] ? b[1] : a[1];
        z = c[0] ? b[2] : a[2];
        y1 = round_down(y * cp - z * sp, 14);
        z1 = round_down(y * sp + z * cp, 14);
        x2 = round_down(x * cy + z1 * sy, 14);
        z2 = round_down(z1 * cy - x * sy, 14);
        v[0] = x2;
        v[1] = y1;
        v[2] = z2;
        for (int k = 0; k < 3; k++) begin
          if (c == 0 || v[k] < lo[k]) lo[k] = v[k];
          if (c == 0 || v[k] > hi[k]) hi[k] = v[k];
        end
      end
      clear_union();
    end else begin
      // Size mode: a centered box, or one standing on Y = 0.
      for (int k = 0; k < 3; k++) begin
        s = longint'(size_q[k*20 +: 20]);
        sc = longint'(scale_q[k*16 +: 16]);
        h = round_down(s * sc, 13);
        lo[k] = -h;
        hi[k] = h;
        if (k == 1 && mode_q[1]) begin
          lo[k] = 0;
          hi[k] = round_down(s * sc, 12);
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      x = sext20(pos_q[k*20 +: 20]);
      wb.coords[k*20 +: 20] = 20'(clamp(lo[k] + x, clip));
      wb.coords[(k+3)*20 +: 20] = 20'(clamp(hi[k] + x, clip));
    end
    wb.clip = clip;
    expected_boxes.push_back(wb);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d (result %0d)",
             what, got, want, results_seen);
    fail_count++;
  endtask

  task automatic compare_world_box(input logic [119:0] d, input logic clip);
    world_box_t wb;
    string names [6] = '{"box_lo_x", "box_lo_y", "box_lo_z", "box_hi_x", "box_hi_y",
                         "box_hi_z"};
    if (expected_boxes.size() == 0) begin
      report_mismatch("unexpected result beat", 1, 0);
      return;
    end
    wb = expected_boxes.pop_front();
    for (int k = 0; k < 6; k++) begin
      if (d[k*20 +: 20] !== wb.coords[k*20 +: 20])
        report_mismatch(names[k], sext20(d[k*20 +: 20]), sext20(wb.coords[k*20 +: 20]));
    end
    if (clip !== wb.clip) report_mismatch("clipped", clip, wb.clip);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
      size_q <= SizeReset;
      scale_q <= ScaleReset;
      pos_q <= PosReset;
      ang_q <= AngReset;
      clear_union();
      expected_boxes.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_BOX_MODE: mode_q <= cfg_data_i[1:0];
          REG_SIZE:     size_q <= cfg_data_i[59:0];
          REG_SCALE:    scale_q <= cfg_data_i[47:0];
          REG_POSITION: pos_q <= cfg_data_i[59:0];
          REG_ANGLES:   ang_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_world_box(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        compare_world_box(m_axis_tdata, m_axis_tuser);
        results_seen++;
      end
    end
  end

  initial begin
    fail_count = 0;
    results_seen = 0;
  end

  always_comb pending = expected_boxes.size();

endmodule

// ===== dv/tb_rotated_bounding_box.sv =====
// Testbench top for the rotated bounding box block: clock, reset, stimulus and
// verdict. Depends on rbb_pkg, rotated_bounding_box and rbb_scoreboard.
module tb_rotated_bounding_box;
  import rbb_pkg::*;

  // An index that maps to no register; writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd5;
  localparam logic [19:0] CoordPos = 20'h7ffff;
  localparam logic [19:0] CoordNeg = 20'h80000;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [119:0]        s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [119:0]        m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int fail_count;
  int pending;
  int results_seen;
  int boxes_sent;
  int phases_run;
  int burst_left;
  logic steady_phase;
  logic squeeze_req;
  logic squeeze_done;

  rotated_bounding_box u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  rbb_scoreboard u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count, .pending, .results_seen
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: the slowest legal run is far shorter than this.
  initial begin
    #20000000;
    $display("timeout with %0d results outstanding", pending);
    $display("** rotated_bounding_box: FAILED **");
    $finish;
  end

  // Receiver. It switches between always ready, coin-flip ready and mostly
  // stalled. Once, on request, it holds off for a long stretch so the job queue
  // and the output register fill and the block pushes back on its input.
  initial begin
    int rx_mode;
    int rx_cycles;
    rx_mode = 0;
    rx_cycles = 0;
    squeeze_done = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (squeeze_req && !squeeze_done) begin
        m_axis_tready <= 1'b0;
        repeat (2000) @(posedge clk_i);
        squeeze_done = 1'b1;
      end
      rx_cycles++;
      if (rx_cycles % 300 == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // One configuration beat. The input is closed first and every expected box
  // drained, so no job is in flight when a register changes.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one mesh box beat. Outside steady phases the sender works in bursts
  // with random gaps between them.
  task automatic send_box(input logic [119:0] coords, input logic last);
    int gap;
    if (!steady_phase) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 20);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= coords;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    boxes_sent++;
  endtask

  // Drains every expected box, then keeps the input closed longer than a
  // geometry job takes, so the block is idle before the next register write.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    phases_run++;
  endtask

  function automatic logic [19:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 20'($urandom);
      1: return CoordPos;
      2: return CoordNeg;
      3: return 20'($urandom_range(0, 8191)) - 20'd4096;
      default: return 20'($urandom_range(0, 131071)) - 20'd65536;
    endcase
  endfunction

  function automatic logic [119:0] pick_box();
    logic [119:0] d;
    for (int k = 0; k < 6; k++) d[k*20 +: 20] = pick_coord();
    return d;
  endfunction

  function automatic logic [59:0] rand60();
    return {28'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 3)) << 14;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h1000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [119:0] d;
    logic [59:0] v;
    int n_obj;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_BOX_MODE;
    cfg_data_i = '0;
    boxes_sent = 0;
    phases_run = 0;
    burst_left = 0;
    steady_phase = 1'b0;
    squeeze_req = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: geometry mode at reset scale and no rotation. Full range box,
    // swapped corners, then a three-box object.
    write_reg(REG_BOX_MODE, 60'd1);
    send_box({CoordPos, CoordPos, CoordPos, CoordNeg, CoordNeg, CoordNeg}, 1'b1);
    send_box({20'd100, 20'hfff00, 20'd5000, 20'hff000, 20'd300, 20'hfec00}, 1'b1);
    send_box({20'd10, 20'd20, 20'd30, 20'd1, 20'd2, 20'd3}, 1'b0);
    send_box({20'hffff0, 20'd4, 20'd4, 20'hffff0, 20'd3, 20'd3}, 1'b0);
    send_box({20'd700, 20'd700, 20'd700, 20'd600, 20'd600, 20'd600}, 1'b1);
    wait_idle();

    // Directed: quarter-turn angles, largest scale, largest position.
    write_reg(REG_ANGLES, {28'd0, 16'h4000, 16'hc000});
    write_reg(REG_SCALE, 60'hffff_ffff_ffff);
    write_reg(REG_POSITION, {CoordPos, CoordPos, CoordPos});
    send_box({CoordPos, CoordPos, CoordPos, CoordNeg, CoordNeg, CoordNeg}, 1'b1);
    send_box({20'd256, 20'd512, 20'd768, 20'hfff00, 20'hffe00, 20'hffd00}, 1'b1);
    write_reg(REG_ANGLES, {28'd0, 16'hffff, 16'h2000});
    send_box({20'd2560, 20'd0, 20'd256, 20'h0, 20'hff600, 20'h0}, 1'b1);
    wait_idle();

    // Directed: size mode with the largest size, then standing on the bottom,
    // then a zero scale. The corner fields and tlast do not matter here.
    write_reg(REG_BOX_MODE, 60'd0);
    write_reg(REG_SIZE, {CoordPos, 20'hfffff, 20'hfffff});
    write_reg(REG_POSITION, {CoordNeg, CoordNeg, CoordNeg});
    send_box(pick_box(), 1'b0);
    send_box(pick_box(), 1'b1);
    write_reg(REG_BOX_MODE, 60'd2);
    write_reg(REG_POSITION, 60'd0);
    send_box(pick_box(), 1'b1);
    write_reg(REG_SCALE, 60'd0);
    send_box(pick_box(), 1'b0);
    write_reg(RegUnused, rand60());
    send_box(pick_box(), 1'b1);
    wait_idle();

    // Random phases. Each picks a fresh register set; geometry mode dominates
    // and sends whole objects of random length with random content.
    for (int ph = 0; ph < 12; ph++) begin
      v = rand60();
      v[1:0] = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 1) << 1) : 2'd1;
      if (ph == 1) v[1:0] = 2'd0;
      write_reg(REG_BOX_MODE, v);
      write_reg(REG_SIZE, ($urandom_range(0, 3) == 0) ? rand60() :
                {8'($urandom), 12'($urandom), 8'($urandom), 12'($urandom),
                 8'($urandom), 12'($urandom)} & 60'h0ffff_0ffff_0ffff);
      write_reg(REG_SCALE, {12'($urandom), pick_scale(), pick_scale(), pick_scale()});
      v = rand60();
      if ($urandom_range(0, 1)) v = {pick_coord(), pick_coord(), pick_coord()};
      write_reg(REG_POSITION, v);
      write_reg(REG_ANGLES, {28'($urandom), pick_angle(), pick_angle()});
      if ($urandom_range(0, 2) == 0) write_reg(RegUnused + 3'($urandom_range(0, 2)), rand60());
      steady_phase = ($urandom_range(0, 3) == 0);
      squeeze_req = (ph == 1);
      n_obj = 0;
      while (n_obj < 150) begin
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        for (int j = 0; j < len; j++) begin
          d = pick_box();
          send_box(d, j == len - 1);
        end
        n_obj += len;
      end
      wait_idle();
    end

    $display("sent %0d mesh box beats over %0d phases, checked %0d world boxes",
             boxes_sent, phases_run, results_seen);
    $display("long output stall exercised: %0d", squeeze_done);
    if (fail_count == 0) begin
      $display("** rotated_bounding_box: PASSED **");
    end else begin
      $display("** rotated_bounding_box: FAILED **");
    end
    $finish;
  end

endmodule

// ===== rotated_bounding_box.f =====
design/rbb_pkg.sv
design/rbb_queue.sv
design/rbb_front.sv
design/rbb_back.sv
design/rotated_bounding_box.sv
design/rbb_checker.sv
dv/rbb_checker.sv
dv/tb_rotated_bounding_box.sv
